// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files that carry checks; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define TPR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
// Implication checked on every rising clock edge outside reset.
`define TPR_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`else
`define TPR_ASSERT(lbl, prop)
`define TPR_ASSERT_IMP(lbl, pre, post)
`endif
`endif

// ===== hdl/tpr_pkg.sv =====
// Shared types and constants of the timer prescaler and reload calculator.
`default_nettype none
package tpr_pkg;
    localparam int CLK_W     = 29;
    localparam int IN_W      = 32;
    localparam int CNT_W     = 16;
    localparam int REM_W     = IN_W + 1;
    localparam int QUO_W     = CLK_W;
    localparam int NUM_CELLS = CLK_W;
    localparam logic [CLK_W-1:0] CLK_RESET = 29'd240000000;
    localparam logic [QUO_W-1:0] Q_LIMIT   = 29'd65536;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_TOOHIGH = 2'd2,
        ST_NOFIT   = 2'd3
    } t_status;

    typedef struct packed {
        t_status          st;
        logic             direct;
        logic [CNT_W-1:0] k0;
        logic [CNT_W-1:0] arr;
    } t_side;

    typedef struct packed {
        logic             vld;
        logic [REM_W-1:0] rem;
        logic [CLK_W-1:0] num;
        logic [IN_W-1:0]  den;
        logic [QUO_W-1:0] quot;
        t_side            side;
    } t_div;
endpackage
`default_nettype wire

// ===== hdl/timer_prescaler_reload_calc.sv =====
// Top level of the timer prescaler and auto-reload calculator.
`default_nettype none
// For each requested update frequency item the block returns a 16-bit
// prescaler, a 16-bit auto-reload value and a 2-bit status (0 ok, 1 zero
// frequency, 2 above half the timer clock, 3 no fitting pair); on an error
// both values are zero. The quotient q = clock_hz / target_hz is formed in a
// row of 29 division cells, one quotient bit per cell. Every later quotient
// reduces to q / k for k = (q >> 16) and k + 1, which two further rows of 29
// cells compute side by side, so the first-choice and the bumped prescaler
// are both ready at the end. The pipeline takes one item per clock cycle while
// no finished result is stuck at the output; an accepted item passes the input
// register, the first cell row, the two parallel cell rows and the output register. The whole
// pipeline advances together and holds while a finished result waits in the
// output register. The clock rate register resets to 240000000 and is
// written over its own channel, which is always ready.
module timer_prescaler_reload_calc (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request channel. tdata: target_hz [31:0].
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,
    // Result channel. tdata: prescaler [15:0], reload [31:16].
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,
    // tuser: status [1:0].
    output logic [1:0]       o_m_tuser,
    // Configuration channel carrying clock_hz.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [28:0] i_cfg_data
);
    logic [tpr_pkg::CLK_W-1:0] r_clk_hz;
    logic                      w_en;
    tpr_pkg::t_div             r_in;
    tpr_pkg::t_div             n_in;
    tpr_pkg::t_div             w_a_out;
    tpr_pkg::t_div             w_b1_in;
    tpr_pkg::t_div             w_b2_in;
    tpr_pkg::t_div             w_b1_out;
    tpr_pkg::t_div             w_b2_out;
    tpr_pkg::t_side            w_mside;
    logic [12:0]               w_k0;
    logic                      r_ov;
    logic [tpr_pkg::CNT_W-1:0] r_psc;
    logic [tpr_pkg::CNT_W-1:0] r_arr;
    tpr_pkg::t_status          r_st;
    logic [tpr_pkg::CNT_W-1:0] n_psc;
    logic [tpr_pkg::CNT_W-1:0] n_arr;
    tpr_pkg::t_status          n_st;

    // The whole pipeline moves unless a result is stuck at the output.
    assign w_en        = !r_ov || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= tpr_pkg::CLK_RESET;
        end else if (i_cfg_valid) begin
            r_clk_hz <= i_cfg_data;
        end
    end

    // Input stage: range checks and the setup of the first division.
    always_comb begin
        n_in = '0;
        n_in.vld  = i_s_tvalid;
        n_in.num  = r_clk_hz;
        n_in.den  = (i_s_tdata == '0) ? 32'd1 : i_s_tdata;
        n_in.side.st = tpr_pkg::ST_OK;
        if (i_s_tdata == '0) begin
            n_in.side.st = tpr_pkg::ST_ZERO;
        end else if (i_s_tdata > {4'd0, r_clk_hz[tpr_pkg::CLK_W-1:1]}) begin
            n_in.side.st = tpr_pkg::ST_TOOHIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else if (w_en) begin
            r_in <= n_in;
        end
    end

    tpr_div_chain u_chain_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_d     (r_in),
        .o_d     (w_a_out)
    );

    // Between the rows: the direct reload q - 1 fits when q <= 65536;
    // otherwise the prescaler divides by k0 = q >> 16 or by k0 + 1.
    always_comb begin
        w_k0 = w_a_out.quot[tpr_pkg::QUO_W-1:16];
        w_mside        = w_a_out.side;
        w_mside.direct = w_a_out.quot <= tpr_pkg::Q_LIMIT;
        w_mside.k0     = {3'd0, w_k0};
        w_mside.arr    = w_a_out.quot[15:0] - 16'd1;

        w_b1_in = '0;
        w_b1_in.vld  = w_a_out.vld;
        w_b1_in.num  = w_a_out.quot;
        w_b1_in.den  = (w_k0 == '0) ? 32'd1 : {19'd0, w_k0};
        w_b1_in.side = w_mside;

        w_b2_in = w_b1_in;
        w_b2_in.den = {19'd0, w_k0} + 32'd1;
    end

    tpr_div_chain u_chain_b1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_d     (w_b1_in),
        .o_d     (w_b1_out)
    );

    tpr_div_chain u_chain_b2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_d     (w_b2_in),
        .o_d     (w_b2_out)
    );

    // Final choice between the direct, first and bumped prescaler.
    always_comb begin
        n_psc = '0;
        n_arr = '0;
        n_st  = w_b1_out.side.st;
        if (w_b1_out.side.st == tpr_pkg::ST_OK) begin
            if (w_b1_out.side.direct) begin
                n_arr = w_b1_out.side.arr;
            end else if (w_b1_out.quot <= tpr_pkg::Q_LIMIT) begin
                n_psc = w_b1_out.side.k0 - 16'd1;
                n_arr = w_b1_out.quot[15:0] - 16'd1;
            end else if (w_b2_out.quot <= tpr_pkg::Q_LIMIT) begin
                n_psc = w_b1_out.side.k0;
                n_arr = w_b2_out.quot[15:0] - 16'd1;
            end else begin
                n_st = tpr_pkg::ST_NOFIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov  <= w_b1_out.vld;
            r_psc <= n_psc;
            r_arr <= n_arr;
            r_st  <= n_st;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_arr, r_psc};
    assign o_m_tuser  = r_st;

`include "assert_macros.svh"
    // An error result never carries a prescaler or reload value.
    `TPR_ASSERT_IMP(a_err_zero, r_ov && (r_st != tpr_pkg::ST_OK), (r_psc == '0) && (r_arr == '0))
    // A nonzero prescaler is only chosen when the reload lies in the upper half.
    `TPR_ASSERT_IMP(a_psc_arr, r_ov && (r_st == tpr_pkg::ST_OK) && (r_psc != '0), r_arr >= 16'd32767)
    // The two quotient rows stay in lock step.
    `TPR_ASSERT(a_rows_sync, w_b1_out.vld == w_b2_out.vld)
endmodule
`default_nettype wire

// ===== hdl/tpr_div_cell.sv =====
// One restoring division cell: produces one quotient bit per item.
`default_nettype none
module tpr_div_cell (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire tpr_pkg::t_div i_d,
    output tpr_pkg::t_div     o_d
);
    tpr_pkg::t_div r_d;
    tpr_pkg::t_div n_d;
    logic [tpr_pkg::REM_W-1:0] w_sh;
    logic                      w_ge;

    always_comb begin
        w_sh = {i_d.rem[tpr_pkg::REM_W-2:0], i_d.num[tpr_pkg::CLK_W-1]};
        w_ge = w_sh >= {1'b0, i_d.den};
        n_d = i_d;
        n_d.rem  = w_ge ? (w_sh - {1'b0, i_d.den}) : w_sh;
        n_d.num  = {i_d.num[tpr_pkg::CLK_W-2:0], 1'b0};
        n_d.quot = {i_d.quot[tpr_pkg::QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

// ===== hdl/tpr_div_chain.sv =====
// Row of division cells, one quotient bit per cell, advancing in lock step.
`default_nettype none
module tpr_div_chain (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire tpr_pkg::t_div i_d,
    output tpr_pkg::t_div      o_d
);
    tpr_pkg::t_div w_link [0:tpr_pkg::NUM_CELLS];

    assign w_link[0] = i_d;

    for (genvar g = 0; g < tpr_pkg::NUM_CELLS; g++) begin : g_cell
        tpr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_d     (w_link[g]),
            .o_d     (w_link[g+1])
        );
    end

    assign o_d = w_link[tpr_pkg::NUM_CELLS];
endmodule
`default_nettype wire
